>>> hw/rtl/crq_pkg.sv
`timescale 1ns / 1ps

package crq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_PARAM_BYTES = 8;

    localparam int DEV_W      = 48;
    localparam int CODE_W     = 8;
    localparam int PRM_MAX_W  = 64;
    localparam int BUD_W      = 8;

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_DUP    = 3'd1,
        ST_FULL   = 3'd2,
        ST_DONE   = 3'd3,
        ST_RETRY  = 3'd4,
        ST_FAILED = 3'd5
    } t_status;

    typedef struct packed {
        logic                 mode;
        logic [DEV_W-1:0]     device_addr;
        logic [CODE_W-1:0]    command_code;
        logic [PRM_MAX_W-1:0] command_params;
        logic [BUD_W-1:0]     retry_budget;
        logic                 success;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic                 head_valid;
        logic [DEV_W-1:0]     head_device;
        logic [CODE_W-1:0]    head_command;
        logic [PRM_MAX_W-1:0] head_params;
    } t_out_item;

    typedef struct packed {
        logic dev_eq;
        logic tag_eq;
        logic budget_last;
    } t_cmp_res;

endpackage

>>> hw/rtl/crq_cmp.sv
`timescale 1ns / 1ps

module crq_cmp
    import crq_pkg::*;
#(
    parameter int PRM_W = 8 * DEF_PARAM_BYTES
) (
    input  logic [DEV_W-1:0]  i_ent_dev,
    input  logic [CODE_W-1:0] i_ent_code,
    input  logic [PRM_W-1:0]  i_ent_prm,
    input  logic [BUD_W-1:0]  i_ent_bud,
    input  logic [DEV_W-1:0]  i_key_dev,
    input  logic [CODE_W-1:0] i_key_code,
    input  logic [PRM_W-1:0]  i_key_prm,
    output t_cmp_res          o_res,
    output logic [BUD_W-1:0]  o_bud_dec
);

    always_comb begin
        o_res.dev_eq      = (i_ent_dev == i_key_dev);
        o_res.tag_eq      = (i_ent_code == i_key_code) && (i_ent_prm == i_key_prm);
        o_res.budget_last = (i_ent_bud <= BUD_W'(1));
        o_bud_dec         = i_ent_bud - BUD_W'(1);
    end

endmodule

>>> hw/rtl/crq_seq.sv
`timescale 1ns / 1ps

module crq_seq
    import crq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int PARAM_BYTES = DEF_PARAM_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_idle,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_out_item o_res
);

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int PRM_W   = 8 * PARAM_BYTES;
    localparam int ENTRY_W = DEV_W + CODE_W + PRM_W + BUD_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_CPL_RD  = 6'b000100,
        S_CPL     = 6'b001000,
        S_HEAD_RD = 6'b010000,
        S_OUT     = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_off, n_off;
    logic                r_pend, n_pend;
    logic                r_dup, n_dup;
    t_status             r_status, n_status;
    logic [DEV_W-1:0]    r_key_dev, n_key_dev;
    logic [CODE_W-1:0]   r_key_code, n_key_code;
    logic [PRM_W-1:0]    r_key_prm, n_key_prm;
    logic [BUD_W-1:0]    r_key_bud, n_key_bud;
    logic                r_key_ok, n_key_ok;

    logic [ENTRY_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]  r_rdata;
    logic [IDX_W-1:0]    raddr;
    logic [IDX_W-1:0]    waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic                we;

    logic [DEV_W-1:0]    rd_dev;
    logic [CODE_W-1:0]   rd_code;
    logic [PRM_W-1:0]    rd_prm;
    logic [BUD_W-1:0]    rd_bud;
    logic [BUD_W-1:0]    bud_dec;
    t_cmp_res            cmp;
    logic                issue;
    logic                full;

    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign rd_dev  = r_rdata[ENTRY_W-1 -: DEV_W];
    assign rd_code = r_rdata[PRM_W+BUD_W+CODE_W-1 -: CODE_W];
    assign rd_prm  = r_rdata[PRM_W+BUD_W-1 -: PRM_W];
    assign rd_bud  = r_rdata[BUD_W-1:0];

    crq_cmp #(
        .PRM_W (PRM_W)
    ) u_cmp (
        .i_ent_dev  (rd_dev),
        .i_ent_code (rd_code),
        .i_ent_prm  (rd_prm),
        .i_ent_bud  (rd_bud),
        .i_key_dev  (r_key_dev),
        .i_key_code (r_key_code),
        .i_key_prm  (r_key_prm),
        .o_res      (cmp),
        .o_bud_dec  (bud_dec)
    );

    assign raddr = (r_state == S_SCAN) ? slot(r_head, r_off) : r_head;
    assign issue = (r_off != r_count);
    assign full  = (r_count == CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_off      = r_off;
        n_pend     = r_pend;
        n_dup      = r_dup;
        n_status   = r_status;
        n_key_dev  = r_key_dev;
        n_key_code = r_key_code;
        n_key_prm  = r_key_prm;
        n_key_bud  = r_key_bud;
        n_key_ok   = r_key_ok;
        we         = 1'b0;
        waddr      = r_head;
        wdata      = {r_key_dev, r_key_code, r_key_prm, r_key_bud};
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key_dev  = i_item.device_addr;
                    n_key_code = i_item.command_code;
                    n_key_prm  = i_item.command_params[PRM_W-1:0];
                    n_key_bud  = i_item.retry_budget;
                    n_key_ok   = i_item.success;
                    n_off      = '0;
                    n_pend     = 1'b0;
                    n_dup      = 1'b0;
                    if (i_item.mode) begin
                        if (r_count == '0) begin
                            n_status = ST_DONE;
                            n_state  = S_HEAD_RD;
                        end else begin
                            n_state  = S_CPL_RD;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_off = r_off + CNT_W'(1);
                end
                n_pend = issue;
                if (r_pend && cmp.dev_eq) begin
                    n_dup = cmp.tag_eq;
                end
                if (!issue && !r_pend) begin
                    if (r_dup) begin
                        n_status = ST_DUP;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        we       = 1'b1;
                        waddr    = slot(r_head, r_count);
                        n_count  = r_count + CNT_W'(1);
                        n_status = ST_ADDED;
                    end
                    n_state = S_HEAD_RD;
                end
            end
            S_CPL_RD: begin
                n_state = S_CPL;
            end
            S_CPL: begin
                if (r_key_ok || cmp.budget_last) begin
                    n_head   = slot(r_head, CNT_W'(1));
                    n_count  = r_count - CNT_W'(1);
                    n_status = r_key_ok ? ST_DONE : ST_FAILED;
                end else begin
                    we    = 1'b1;
                    wdata = {rd_dev, rd_code, rd_prm, bud_dec};
                    if (r_count != CNT_W'(1)) begin
                        waddr  = slot(r_head, r_count);
                        n_head = slot(r_head, CNT_W'(1));
                    end
                    n_status = ST_RETRY;
                end
                n_state = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_off    <= '0;
            r_pend   <= 1'b0;
            r_dup    <= 1'b0;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_off    <= n_off;
            r_pend   <= n_pend;
            r_dup    <= n_dup;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_dev  <= n_key_dev;
        r_key_code <= n_key_code;
        r_key_prm  <= n_key_prm;
        r_key_bud  <= n_key_bud;
        r_key_ok   <= n_key_ok;
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        o_res.status       = r_status;
        o_res.head_valid   = (r_count != '0);
        o_res.head_device  = '0;
        o_res.head_command = '0;
        o_res.head_params  = '0;
        if (r_count != '0) begin
            o_res.head_device  = rd_dev;
            o_res.head_command = rd_code;
            o_res.head_params  = PRM_MAX_W'(rd_prm);
        end
    end

endmodule

>>> hw/rtl/command_retry_queue_core.sv
`timescale 1ns / 1ps

// Channel   Valid        Ready        Payload
// input     i_in_valid   o_in_ready   i_in_item  (t_in_item)
// output    o_out_valid  i_out_ready  o_out_item (t_out_item)
//
// An enqueue scans the queue for a duplicate, reading one queue entry per cycle, and then
// reads the head entry; its result reaches o_out_valid through the output register.
// A completion reads and updates the head entry (not on an empty queue), then reads the head.
// Reset empties the queue at once; entry storage needs no clearing.
// A new item is accepted while the previous result waits in the output register;
// the next result waits in the sequencer until that register frees.

module command_retry_queue_core
    import crq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int PARAM_BYTES = DEF_PARAM_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      idle;
    logic      res_valid;
    logic      res_ready;
    t_out_item res;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item, n_out_item;

    crq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PARAM_BYTES (PARAM_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && idle),
        .i_item      (i_in_item),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign o_in_ready = idle;
    assign res_ready  = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out_item  = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hw/rtl/crq_checker.sv
`timescale 1ns / 1ps

module crq_checker
    import crq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input accepted twice in consecutive cycles.");

    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.head_valid |->
            o_out_item.head_device == '0 && o_out_item.head_command == '0 &&
            o_out_item.head_params == '0)
        else $error("Empty queue shows nonzero head fields.");

    a_added_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_ADDED || o_out_item.status == ST_RETRY ||
                        o_out_item.status == ST_DUP) |-> o_out_item.head_valid)
        else $error("Queue reported empty after an add, retry or duplicate.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("Stalled result item changed.");

endmodule

bind command_retry_queue_core crq_checker u_crq_checker (.*);

>>> verif/crq_test_pkg.sv
`timescale 1ns / 1ps

package crq_test_pkg;

    import crq_pkg::*;

    localparam int SLOTS        = DEF_QUEUE_DEPTH;
    localparam int PRM_BITS     = 8 * DEF_PARAM_BYTES;
    localparam int REPORT_LIMIT = 10;

    localparam logic MODE_ENQUEUE  = 1'b0;
    localparam logic MODE_COMPLETE = 1'b1;

    typedef struct packed {
        logic [DEV_W-1:0]     device;
        logic [CODE_W-1:0]    code;
        logic [PRM_MAX_W-1:0] params;
        logic [BUD_W-1:0]     budget;
    } t_queued_cmd;

    class retry_queue_board;
        t_queued_cmd slot_q[SLOTS];
        int unsigned head_slot;
        int unsigned live_count;
        t_out_item   expected_reports[$];
        int unsigned mismatches;
        int unsigned report_index;

        function new();
            head_slot    = 0;
            live_count   = 0;
            mismatches   = 0;
            report_index = 0;
        endfunction

        function logic [PRM_MAX_W-1:0] param_mask();
            if (PRM_BITS >= PRM_MAX_W) begin
                return '1;
            end
            return (64'd1 << PRM_BITS) - 64'd1;
        endfunction

        function void drop_head();
            head_slot = (head_slot + 1) % SLOTS;
            live_count--;
        endfunction

        function t_out_item predict_report(t_in_item cmd);
            t_out_item   rep;
            t_status     st;
            bit          found;
            int unsigned last;
            int unsigned k;
            logic [PRM_MAX_W-1:0] prm;

            rep = '0;
            prm = cmd.command_params & param_mask();
            if (cmd.mode == MODE_COMPLETE) begin
                if (live_count == 0) begin
                    st = ST_DONE;
                end else if (cmd.success) begin
                    drop_head();
                    st = ST_DONE;
                end else if (slot_q[head_slot].budget <= 1) begin
                    drop_head();
                    st = ST_FAILED;
                end else begin
                    slot_q[head_slot].budget = slot_q[head_slot].budget - 1;
                    if (live_count > 1) begin
                        slot_q[(head_slot + live_count) % SLOTS] = slot_q[head_slot];
                        head_slot = (head_slot + 1) % SLOTS;
                    end
                    st = ST_RETRY;
                end
            end else begin
                found = 1'b0;
                last  = 0;
                for (int unsigned i = 0; i < live_count; i++) begin
                    k = (head_slot + i) % SLOTS;
                    if (slot_q[k].device == cmd.device_addr) begin
                        found = 1'b1;
                        last  = k;
                    end
                end
                if (found && slot_q[last].code == cmd.command_code &&
                    slot_q[last].params == prm) begin
                    st = ST_DUP;
                end else if (live_count >= SLOTS) begin
                    st = ST_FULL;
                end else begin
                    slot_q[(head_slot + live_count) % SLOTS] = '{
                        device: cmd.device_addr,
                        code:   cmd.command_code,
                        params: prm,
                        budget: cmd.retry_budget
                    };
                    live_count++;
                    st = ST_ADDED;
                end
            end
            rep.status = st;
            if (live_count > 0) begin
                rep.head_valid   = 1'b1;
                rep.head_device  = slot_q[head_slot].device;
                rep.head_command = slot_q[head_slot].code;
                rep.head_params  = slot_q[head_slot].params;
            end
            return rep;
        endfunction

        function void note_command(t_in_item cmd);
            expected_reports.push_back(predict_report(cmd));
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;

            report_index++;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("report %0d arrived with nothing expected: status %0d valid %0b",
                             report_index, got.status, got.head_valid);
                end
                return;
            end
            want = expected_reports.pop_front();
            if (got.status !== want.status || got.head_valid !== want.head_valid ||
                got.head_device !== want.head_device ||
                got.head_command !== want.head_command ||
                got.head_params !== want.head_params) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("report %0d expected: status %0d valid %0b dev %h cmd %h prm %h",
                             report_index, want.status, want.head_valid, want.head_device,
                             want.head_command, want.head_params);
                    $display("report %0d actual:   status %0d valid %0b dev %h cmd %h prm %h",
                             report_index, got.status, got.head_valid, got.head_device,
                             got.head_command, got.head_params);
                end
            end
        endfunction
    endclass

endpackage

>>> verif/command_retry_queue_core_test.sv
`timescale 1ns / 1ps

module command_retry_queue_core_test;

    import crq_pkg::*;
    import crq_test_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_ITEMS  = 1075;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          LONG_HOLD     = 400;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    retry_queue_board board = new();

    bit               calm              = 1'b0;
    bit               long_hold_pending = 1'b0;
    int unsigned      cycle_count       = 0;
    t_in_item         recent_enqueues[8];
    int unsigned      recent_fill       = 0;
    int unsigned      recent_next       = 0;
    logic [DEV_W-1:0] device_pool[4];

    command_retry_queue_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("command_retry_queue_core: mismatch");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (calm || roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item make_enqueue(logic [DEV_W-1:0] dev, logic [CODE_W-1:0] code,
                                              logic [PRM_MAX_W-1:0] prm,
                                              logic [BUD_W-1:0] bud);
        t_in_item c;

        c.mode           = MODE_ENQUEUE;
        c.device_addr    = dev;
        c.command_code   = code;
        c.command_params = prm;
        c.retry_budget   = bud;
        c.success        = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic t_in_item make_completion(logic ok);
        t_in_item c;

        c.mode           = MODE_COMPLETE;
        c.device_addr    = DEV_W'({$urandom, $urandom});
        c.command_code   = CODE_W'($urandom);
        c.command_params = {$urandom, $urandom};
        c.retry_budget   = BUD_W'($urandom);
        c.success        = ok;
        return c;
    endfunction

    function automatic t_in_item random_command(int unsigned enqueue_pct);
        t_in_item         c;
        logic [DEV_W-1:0] dev;

        if ($urandom_range(0, 99) >= enqueue_pct) begin
            return make_completion(1'($urandom_range(0, 99) < 45));
        end
        if (recent_fill > 0 && $urandom_range(0, 99) < 20) begin
            c = recent_enqueues[$urandom_range(0, recent_fill - 1)];
            c.success = 1'($urandom_range(0, 1));
            return c;
        end
        dev = ($urandom_range(0, 99) < 70) ? device_pool[$urandom_range(0, 3)]
                                           : DEV_W'({$urandom, $urandom});
        c = make_enqueue(dev,
                         ($urandom_range(0, 99) < 60) ? CODE_W'($urandom_range(0, 2))
                                                      : CODE_W'($urandom),
                         ($urandom_range(0, 99) < 60) ? PRM_MAX_W'($urandom_range(0, 1))
                                                      : {$urandom, $urandom},
                         ($urandom_range(0, 99) < 80) ? BUD_W'($urandom_range(0, 3))
                                                      : BUD_W'($urandom));
        return c;
    endfunction

    task automatic offer(t_in_item cmd);
        i_in_valid <= 1'b1;
        i_in_item  <= cmd;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        board.note_command(cmd);
        if (cmd.mode == MODE_ENQUEUE) begin
            recent_enqueues[recent_next] = cmd;
            recent_next = (recent_next + 1) % 8;
            if (recent_fill < 8) begin
                recent_fill++;
            end
        end
    endtask

    task automatic idle_gap(int unsigned cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    initial begin
        int unsigned stall_left;
        int unsigned roll;

        stall_left = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                board.check_report(o_out_item);
            end
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    stall_left = (roll < 1) ? $urandom_range(20, 60) : $urandom_range(1, 3);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        t_in_item plan[$];

        foreach (device_pool[p]) begin
            device_pool[p] = DEV_W'({$urandom, $urandom});
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        plan.push_back(make_completion(1'b1));
        plan.push_back(make_completion(1'b0));
        plan.push_back(make_enqueue('0, '0, '0, '0));
        plan.push_back(make_enqueue('0, '0, '0, '0));
        plan.push_back(make_completion(1'b0));
        plan.push_back(make_enqueue('1, '1, '1, '1));
        plan.push_back(make_completion(1'b0));
        plan.push_back(make_enqueue('1, '1, '0, 8'd3));
        plan.push_back(make_enqueue('1, '1, '0, 8'd3));
        plan.push_back(make_enqueue('1, '1, '1, 8'd2));
        plan.push_back(make_completion(1'b0));
        plan.push_back(make_enqueue(48'd5, 8'd7, 64'h0123_4567_89ab_cdef, 8'd1));
        for (int i = 0; i < 12; i++) begin
            plan.push_back(make_enqueue(48'h1000 + i, CODE_W'(i), {$urandom, $urandom}, 8'd2));
        end
        plan.push_back(plan[plan.size() - 1]);
        plan.push_back(make_enqueue(48'h2000, 8'h55, 64'h5555, 8'd4));
        plan.push_back(make_completion(1'b1));
        foreach (plan[i]) begin
            offer(plan[i]);
            idle_gap(pick_gap());
        end
        drain();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            calm = ((k / 150) % 4) == 1;
            if (k == 350) begin
                long_hold_pending = 1'b1;
            end
            if (k == 700) begin
                drain();
            end
            offer(random_command((((k / 60) % 2) == 1) ? 30 : 80));
            idle_gap(pick_gap());
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("command_retry_queue_core: match");
        end else begin
            $display("command_retry_queue_core: mismatch");
        end
        $finish;
    end

endmodule
